// ----- hdl/tte_pkg.sv -----
package tte_pkg;

  // History depth and field widths
  localparam int HISTORY_DEPTH = 6;
  localparam int TIME_W        = 32;
  localparam int CFG_W         = 16;
  localparam int TEMPO_W       = 12;
  localparam int ICNT_W        = 3;
  localparam int CFG_IDX_W     = 2;

  // Derived counter and datapath widths
  localparam int TC_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int VCNT_W = $clog2(HISTORY_DEPTH);
  localparam int SUM_W  = CFG_W + $clog2(HISTORY_DEPTH);

  // Twice the tenths-of-BPM numerator for one interval (2 * 600000)
  localparam int TWICE_TENTHS_MS = 1200000;
  localparam longint NUM_MAX = longint'(TWICE_TENTHS_MS) * (HISTORY_DEPTH - 1)
                             + longint'(65535) * (HISTORY_DEPTH - 1);
  localparam int NUM_W  = $clog2(NUM_MAX + 1);
  localparam int DCNT_W = $clog2(NUM_W);

  // Tempo clamp limits in tenths of BPM
  localparam int TEMPO_MIN = 200;
  localparam int TEMPO_MAX = 3000;

  // Register defaults
  localparam logic [CFG_W-1:0] RESET_GAP_DEF    = 16'd2000;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_DEF = 16'd200;
  localparam logic [CFG_W-1:0] MAX_INTERVAL_DEF = 16'd3000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_GAP    = 2'd0,
    REG_MIN_INTERVAL = 2'd1,
    REG_MAX_INTERVAL = 2'd2
  } cfg_reg_t;

endpackage

// ----- hdl/tap_tempo_estimator.sv -----
// Tap tempo estimator: one tap item in, one tempo item out.
// Sequence after accept: scan the stored taps, then check; when an interval is averaged and
//   the sum is nonzero, a restoring divide over NUM_W (23) quotient bits and a clamp follow.
// The next item is taken only after the result loads into the output register; a result
//   still waiting in the output holds it off.
// Reset (synchronous, active low): defaults loaded, tap count zeroed; no clearing pass.
module tap_tempo_estimator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tte_pkg::TIME_W-1:0]      in_tap_time_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tte_pkg::TEMPO_W-1:0]     out_tempo_tenths,
  output logic                            out_updated,
  output logic [tte_pkg::ICNT_W-1:0]      out_interval_count,
  input  logic                            cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tte_pkg::CFG_W-1:0]       cfg_wdata
);
  import tte_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DIV,
    ST_CLAMP,
    ST_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [CFG_W-1:0] reset_gap_r;
  logic [CFG_W-1:0] min_iv_r;
  logic [CFG_W-1:0] max_iv_r;

  // Tap history, newest at entry 0
  logic [TIME_W-1:0] hist_r [HISTORY_DEPTH];
  logic [TC_W-1:0]   tcnt_r;

  // Scan and divide working registers
  logic [IDX_W-1:0]   idx_r;
  logic [TIME_W-1:0]  prev_r;
  logic [SUM_W-1:0]   sum_r;
  logic [VCNT_W-1:0]  vcnt_r;
  logic [NUM_W-1:0]   nq_r;
  logic [SUM_W:0]     rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [TEMPO_W-1:0] work_tempo_r;

  // Result registers
  logic               out_valid_r;
  logic [TEMPO_W-1:0] res_tempo_r;
  logic               res_upd_r;
  logic [ICNT_W-1:0]  res_cnt_r;

  logic               in_acc;
  logic [TIME_W-1:0]  gap;
  logic               hist_clear;
  logic [TC_W-1:0]    base_cnt;
  logic [TC_W-1:0]    new_cnt;
  logic [TIME_W-1:0]  cur_tap;
  logic [TIME_W-1:0]  iv;
  logic               iv_ok;
  logic               scan_last;
  logic [NUM_W-1:0]   num;
  logic [SUM_W+1:0]   trial;
  logic [SUM_W+1:0]   divisor;
  logic               ge;
  logic [TEMPO_W-1:0] clamped;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid          = out_valid_r;
  assign out_tempo_tenths   = res_tempo_r;
  assign out_updated        = res_upd_r;
  assign out_interval_count = res_cnt_r;

  // Gap check and new fill count on accept
  always_comb begin
    gap        = in_tap_time_ms - hist_r[0];
    hist_clear = (tcnt_r != '0) && (gap > TIME_W'(reset_gap_r));
    base_cnt   = hist_clear ? '0 : tcnt_r;
    new_cnt    = (base_cnt == TC_W'(HISTORY_DEPTH)) ? base_cnt : base_cnt + 1'b1;
  end

  // Interval scan: one stored tap per cycle
  always_comb begin
    cur_tap   = hist_r[idx_r];
    iv        = prev_r - cur_tap;
    iv_ok     = (iv >= TIME_W'(min_iv_r)) && (iv <= TIME_W'(max_iv_r));
    scan_last = (TC_W'(idx_r) == tcnt_r - 1'b1);
  end

  // Numerator and one restoring divide step
  always_comb begin
    num     = NUM_W'(vcnt_r) * NUM_W'(TWICE_TENTHS_MS) + NUM_W'(sum_r);
    trial   = {rem_r, nq_r[NUM_W-1]};
    divisor = (SUM_W+2)'({sum_r, 1'b0});
    ge      = (trial >= divisor);
  end

  // Clamp quotient to the tempo range
  always_comb begin
    if (nq_r < NUM_W'(TEMPO_MIN)) begin
      clamped = TEMPO_W'(TEMPO_MIN);
    end else if (nq_r > NUM_W'(TEMPO_MAX)) begin
      clamped = TEMPO_W'(TEMPO_MAX);
    end else begin
      clamped = nq_r[TEMPO_W-1:0];
    end
  end

  // Sequencer, history and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tcnt_r      <= '0;
      reset_gap_r <= RESET_GAP_DEF;
      min_iv_r    <= MIN_INTERVAL_DEF;
      max_iv_r    <= MAX_INTERVAL_DEF;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RESET_GAP:    reset_gap_r <= cfg_wdata;
          REG_MIN_INTERVAL: min_iv_r    <= cfg_wdata;
          REG_MAX_INTERVAL: max_iv_r    <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop a delivered item unless the next one loads in its place
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            hist_r[0] <= in_tap_time_ms;
            for (int k = 1; k < HISTORY_DEPTH; k++) begin
              hist_r[k] <= hist_r[k-1];
            end
            tcnt_r <= new_cnt;
            prev_r <= in_tap_time_ms;
            idx_r  <= IDX_W'(1);
            sum_r  <= '0;
            vcnt_r <= '0;
            state_r <= (new_cnt >= TC_W'(2)) ? ST_SCAN : ST_CHECK;
          end
        end
        ST_SCAN: begin
          if (iv_ok) begin
            sum_r  <= sum_r + SUM_W'(iv[CFG_W-1:0]);
            vcnt_r <= vcnt_r + 1'b1;
          end
          prev_r <= cur_tap;
          idx_r  <= idx_r + 1'b1;
          if (scan_last) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (vcnt_r == '0) begin
            work_tempo_r <= '0;
            state_r      <= ST_FIN;
          end else if (sum_r == '0) begin
            work_tempo_r <= TEMPO_W'(TEMPO_MAX);
            state_r      <= ST_FIN;
          end else begin
            nq_r    <= num;
            rem_r   <= '0;
            dcnt_r  <= DCNT_W'(NUM_W - 1);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ge) begin
            rem_r <= (SUM_W+1)'(trial - divisor);
          end else begin
            rem_r <= trial[SUM_W:0];
          end
          nq_r   <= {nq_r[NUM_W-2:0], ge};
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == '0) begin
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          work_tempo_r <= clamped;
          state_r      <= ST_FIN;
        end
        ST_FIN: begin
          // Hold the result until the output register frees up
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            res_tempo_r <= work_tempo_r;
            res_upd_r   <= (vcnt_r != '0);
            res_cnt_r   <= ICNT_W'(vcnt_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  a_idle_tempo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_updated |-> out_tempo_tenths == '0)
    else $error("tempo nonzero without update");

  a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated |->
      out_tempo_tenths >= TEMPO_W'(TEMPO_MIN) && out_tempo_tenths <= TEMPO_W'(TEMPO_MAX))
    else $error("tempo outside clamp range");

  a_update_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_updated |-> out_interval_count != '0)
    else $error("update with no averaged interval");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TC_W'(HISTORY_DEPTH))
    else $error("tap count beyond history depth");
`endif

endmodule
